// ===== hdl/radar_ascii_frame_parser_unit_defines.svh =====
// ---------------------------------------------------------------------------
// radar ascii frame parser unit - assertion macros
// shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted
// ---------------------------------------------------------------------------
`ifndef RADAR_ASCII_FRAME_PARSER_UNIT_DEFINES_SVH
`define RADAR_ASCII_FRAME_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define RAFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rafp assertion failed");

// next-cycle implication
`define RAFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rafp assertion failed");

`endif

// ===== hdl/rafp_pkg.sv =====
// ---------------------------------------------------------------------------
// rafp_pkg
// constants, types and helpers for the radar ascii frame parser
// ---------------------------------------------------------------------------
package rafp_pkg;

  localparam int RAFP_BODY_DEPTH = 18;
  // body positions that the decoder looks at (0 .. 13)
  localparam int DEC_SPAN = 14;

  localparam logic [7:0] HDR_A_CH = 8'h31;
  localparam logic [7:0] CR_CH    = 8'h0D;
  localparam logic [7:0] LF_CH    = 8'h0A;
  localparam logic [7:0] POINT_CH = 8'h2E;
  localparam logic [7:0] MINUS_CH = 8'h2D;
  localparam logic [7:0] ZERO_CH  = 8'h30;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DIST = 2'd1,
    ST_BAD_VEL  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_CR   = 4'b0010,
    PH_LF   = 4'b0100,
    PH_BODY = 4'b1000
  } phase_t;

  typedef logic [DEC_SPAN-1:0][7:0] body_view_t;

  typedef struct packed {
    status_t     status;
    logic        dist_upd;
    logic        vel_upd;
    logic [15:0] distance;
    logic [15:0] velocity;
  } dec_res_t;

  // ascii digit value, wrapping, no range check
  function automatic logic [15:0] digit_val(logic [7:0] b);
    return {8'h00, b} - {8'h00, ZERO_CH};
  endfunction

endpackage

// ===== hdl/rafp_decode.sv =====
// ---------------------------------------------------------------------------
// rafp_decode
// decodes an ended body into distance, velocity and a status code
// ---------------------------------------------------------------------------
module rafp_decode
  import rafp_pkg::*;
(
  input  body_view_t body_i,
  output dec_res_t   res_o
);

  logic [15:0] d [DEC_SPAN];
  logic [DEC_SPAN-1:0] pt;

  always_comb begin
    for (int k = 0; k < DEC_SPAN; k++) begin
      d[k]  = digit_val(body_i[k]);
      pt[k] = (body_i[k] == POINT_CH);
    end
  end

  always_comb begin
    res_o          = '0;
    res_o.status   = ST_OK;
    priority if (pt[3]) begin
      res_o.dist_upd = 1'b1;
      res_o.distance = d[2] * 16'd100 + d[4] * 16'd10 + d[5];
      res_o.vel_upd  = 1'b1;
      priority if (pt[8]) begin
        res_o.velocity = d[7] * 16'd100 + d[9] * 16'd10 + d[10];
      end else if (pt[10]) begin
        res_o.velocity = 16'd0 - (d[8] * 16'd1000 + d[9] * 16'd100
                                  + d[11] * 16'd10 + d[12]);
      end else if (pt[9]) begin
        if (body_i[7] == MINUS_CH) begin
          res_o.velocity = 16'd0 - (d[8] * 16'd100 + d[10] * 16'd10 + d[11]);
        end else begin
          res_o.velocity = d[7] * 16'd1000 + d[8] * 16'd100
                           + d[10] * 16'd10 + d[11];
        end
      end else begin
        res_o.vel_upd = 1'b0;
        res_o.status  = ST_BAD_VEL;
      end
    end else if (pt[4]) begin
      res_o.dist_upd = 1'b1;
      res_o.distance = d[2] * 16'd1000 + d[3] * 16'd100 + d[5] * 16'd10 + d[6];
      res_o.vel_upd  = 1'b1;
      priority if (pt[9]) begin
        res_o.velocity = d[8] * 16'd100 + d[10] * 16'd10 + d[11];
      end else if (pt[11]) begin
        res_o.velocity = 16'd0 - (d[9] * 16'd1000 + d[10] * 16'd100
                                  + d[12] * 16'd10 + d[13]);
      end else if (pt[10]) begin
        if (body_i[8] == MINUS_CH) begin
          res_o.velocity = 16'd0 - (d[9] * 16'd100 + d[11] * 16'd10 + d[12]);
        end else begin
          res_o.velocity = d[8] * 16'd1000 + d[9] * 16'd100
                           + d[11] * 16'd10 + d[12];
        end
      end else begin
        res_o.vel_upd = 1'b0;
        res_o.status  = ST_BAD_VEL;
      end
    end else begin
      res_o.status = ST_BAD_DIST;
    end
  end

endmodule

// ===== hdl/radar_ascii_frame_parser_unit.sv =====
// ---------------------------------------------------------------------------
// radar_ascii_frame_parser_unit
// parses ascii distance/velocity frames from a serial byte stream
// ---------------------------------------------------------------------------
// usage
//   input channel: one received serial byte per word (in_rx_byte), taken
//   on in_valid && in_ready. the byte is held in an input register and
//   handled from there once no result waits.
//   result channel: one word per ended frame or body overflow, carrying
//   out_status, out_distance and out_velocity (held values after the frame),
//   taken on out_valid && out_ready. header and body bytes give no word.
//   result path: input register, then hunter, body store and decoder, then
//   the result register, which drives out_valid.
//   throughput: one byte per cycle while no result waits, set by the single
//   input register to result register pass (all in one step).
//   stall: while a result waits, the input register still takes one more
//   byte; it is handled as soon as the result is taken.
//   reset: synchronous, active low; hunter back to the first header byte,
//   held distance and velocity cleared, both channels empty. the body
//   buffer is not cleared.
// ---------------------------------------------------------------------------
`include "radar_ascii_frame_parser_unit_defines.svh"

module radar_ascii_frame_parser_unit
  import rafp_pkg::*;
#(
  parameter int BODY_DEPTH = RAFP_BODY_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [15:0]        out_distance,
  output logic signed [15:0] out_velocity
);

  localparam int IDX_W = $clog2(BODY_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BODY_DEPTH - 1);

  // input register
  logic       in_v_r;
  logic [7:0] in_byte_r;

  // hunter and body state
  phase_t             phase_r, phase_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               prev_cr_r, prev_cr_nxt;
  logic [7:0]         body_r [BODY_DEPTH];
  logic               body_we;

  // held values
  logic [15:0] dist_r, dist_nxt;
  logic [15:0] vel_r, vel_nxt;

  // result register
  logic        out_valid_r;
  status_t     out_status_r;
  logic [15:0] out_dist_r;
  logic [15:0] out_vel_r;

  logic        advance;
  logic        gen_result;
  status_t     res_status;
  logic        body_end;
  body_view_t  view;
  dec_res_t    dec;

  // process the held byte unless a result is still waiting
  assign advance  = in_v_r && (!out_valid_r || out_ready);
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // decoder sees the buffer with the current byte laid over its position
  always_comb begin
    for (int k = 0; k < DEC_SPAN; k++) begin
      view[k] = (idx_r == IDX_W'(k)) ? in_byte_r : body_r[k];
    end
  end

  rafp_decode u_decode (
    .body_i (view),
    .res_o  (dec)
  );

  // frame end needs a stored previous byte, so never at body start
  assign body_end = (idx_r != '0) && prev_cr_r && (in_byte_r == LF_CH);

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    prev_cr_nxt = prev_cr_r;
    dist_nxt    = dist_r;
    vel_nxt     = vel_r;
    body_we     = 1'b0;
    gen_result  = 1'b0;
    res_status  = ST_OK;
    if (advance) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (in_byte_r == HDR_A_CH) begin
            phase_nxt = PH_CR;
          end
        end
        PH_CR: begin
          priority if (in_byte_r == CR_CH) begin
            phase_nxt = PH_LF;
          end else if (in_byte_r == HDR_A_CH) begin
            phase_nxt = PH_CR;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_LF: begin
          priority if (in_byte_r == LF_CH) begin
            phase_nxt = PH_BODY;
            idx_nxt   = '0;
          end else if (in_byte_r == HDR_A_CH) begin
            phase_nxt = PH_CR;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_BODY: begin
          body_we = 1'b1;
          priority if (body_end) begin
            gen_result = 1'b1;
            res_status = dec.status;
            if (dec.dist_upd) begin
              dist_nxt = dec.distance;
            end
            if (dec.vel_upd) begin
              vel_nxt = dec.velocity;
            end
          end else if (idx_r == IDX_LAST) begin
            // buffer full without a frame end
            gen_result = 1'b1;
            res_status = ST_OVERFLOW;
          end else begin
            idx_nxt     = idx_r + IDX_W'(1);
            prev_cr_nxt = (in_byte_r == CR_CH);
          end
          if (gen_result) begin
            phase_nxt = PH_HUNT;
            idx_nxt   = '0;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          idx_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      idx_r     <= '0;
      prev_cr_r <= 1'b0;
      dist_r    <= '0;
      vel_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      prev_cr_r <= prev_cr_nxt;
      dist_r    <= dist_nxt;
      vel_r     <= vel_nxt;
    end
  end

  // body buffer, no reset
  always_ff @(posedge clk) begin
    if (body_we) begin
      body_r[idx_r] <= in_byte_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (gen_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (gen_result) begin
      out_status_r <= res_status;
      out_dist_r   <= dist_nxt;
      out_vel_r    <= vel_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_distance = out_dist_r;
  assign out_velocity = signed'(out_vel_r);

  // checks
  `RAFP_ASSERT_NEXT(a_no_phantom_word, clk, rst_n, (!out_valid_r || out_ready) && !gen_result, !out_valid_r)
  `RAFP_ASSERT_NEXT(a_restart_after_word, clk, rst_n, gen_result, phase_r == PH_HUNT && idx_r == '0)
  `RAFP_ASSERT_NOW(a_index_in_range, clk, rst_n, phase_r == PH_BODY, idx_r <= IDX_LAST)
  `RAFP_ASSERT_NEXT(a_bad_dist_keeps, clk, rst_n, gen_result && res_status == ST_BAD_DIST, $stable(dist_r) && $stable(vel_r))

endmodule

// ===== test/radar_ascii_frame_parser_unit_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// radar_ascii_frame_parser_unit_tb
// checks the ascii frame parser against a local model of the hunter, body
// store and decoder: directed frames first, then random frames, broken
// headers and line noise under changing sender idling and receiver stalls
// ---------------------------------------------------------------------------
module radar_ascii_frame_parser_unit_tb;
  import rafp_pkg::*;

  localparam int WATCHDOG_CYCLES = 400000;
  localparam int CHUNK_BYTES     = 110;
  localparam int MAX_LINES       = 40;

  // one pending byte for the driver; a hold marker makes the sender wait
  // until every expected word has come back
  typedef struct {
    logic [7:0] b;
    bit         hold;
  } rx_item_t;

  typedef struct {
    status_t     st;
    logic [15:0] distance;
    logic [15:0] vel;
  } frame_res_t;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte   = 8'h00;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic [1:0]         out_status;
  logic [15:0]        out_distance;
  logic signed [15:0] out_velocity;

  rx_item_t   rx_q[$];
  frame_res_t frame_res_q[$];

  int idle_pct       = 0;
  int stall_pct      = 0;
  int fed_count      = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  // local copy of the parser state
  phase_t      hunt_ph  = PH_HUNT;
  int          body_pos = 0;
  logic [7:0]  body_mem [RAFP_BODY_DEPTH];
  logic [15:0] held_dist = 16'h0000;
  logic [15:0] held_vel  = 16'h0000;

  radar_ascii_frame_parser_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_distance (out_distance),
    .out_velocity (out_velocity)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // model of the parser
  // ---------------------------------------------------------------------------

  // ascii digit, wrapping, no range check
  function automatic logic [15:0] digit_of(int k);
    return 16'(body_mem[k]) - 16'(ZERO_CH);
  endfunction

  // decode an ended body; distance is taken as soon as its format is known,
  // velocity only when its format is good too
  function automatic status_t decode_frame_body();
    logic [15:0] v;
    if (body_mem[3] == POINT_CH) begin
      held_dist = digit_of(2) * 16'd100 + digit_of(4) * 16'd10 + digit_of(5);
      if (body_mem[8] == POINT_CH) begin
        v = digit_of(7) * 16'd100 + digit_of(9) * 16'd10 + digit_of(10);
      end else if (body_mem[10] == POINT_CH) begin
        v = 16'd0 - (digit_of(8) * 16'd1000 + digit_of(9) * 16'd100
                     + digit_of(11) * 16'd10 + digit_of(12));
      end else if (body_mem[9] == POINT_CH) begin
        if (body_mem[7] == MINUS_CH) begin
          v = 16'd0 - (digit_of(8) * 16'd100 + digit_of(10) * 16'd10 + digit_of(11));
        end else begin
          v = digit_of(7) * 16'd1000 + digit_of(8) * 16'd100
              + digit_of(10) * 16'd10 + digit_of(11);
        end
      end else begin
        return ST_BAD_VEL;
      end
    end else if (body_mem[4] == POINT_CH) begin
      held_dist = digit_of(2) * 16'd1000 + digit_of(3) * 16'd100
                  + digit_of(5) * 16'd10 + digit_of(6);
      if (body_mem[9] == POINT_CH) begin
        v = digit_of(8) * 16'd100 + digit_of(10) * 16'd10 + digit_of(11);
      end else if (body_mem[11] == POINT_CH) begin
        v = 16'd0 - (digit_of(9) * 16'd1000 + digit_of(10) * 16'd100
                     + digit_of(12) * 16'd10 + digit_of(13));
      end else if (body_mem[10] == POINT_CH) begin
        if (body_mem[8] == MINUS_CH) begin
          v = 16'd0 - (digit_of(9) * 16'd100 + digit_of(11) * 16'd10 + digit_of(12));
        end else begin
          v = digit_of(8) * 16'd1000 + digit_of(9) * 16'd100
              + digit_of(11) * 16'd10 + digit_of(12);
        end
      end else begin
        return ST_BAD_VEL;
      end
    end else begin
      return ST_BAD_DIST;
    end
    held_vel = v;
    return ST_OK;
  endfunction

  // feed one accepted byte through the model; queues a word when a frame
  // ends or the body store runs full
  task automatic advance_parser(input logic [7:0] b);
    status_t    st;
    bit         ended;
    frame_res_t res;
    ended = 1'b0;
    case (hunt_ph)
      PH_BODY: begin
        body_mem[body_pos] = b;
        // the first body byte has no previous byte, so it never ends a body
        if (body_pos >= 1 && body_mem[body_pos - 1] == CR_CH && b == LF_CH) begin
          st    = decode_frame_body();
          ended = 1'b1;
        end else if (body_pos + 1 >= RAFP_BODY_DEPTH) begin
          st    = ST_OVERFLOW;
          ended = 1'b1;
        end else begin
          body_pos++;
        end
      end
      PH_LF: begin
        if (b == LF_CH) begin
          hunt_ph  = PH_BODY;
          body_pos = 0;
        end else if (b == HDR_A_CH) begin
          hunt_ph = PH_CR;
        end else begin
          hunt_ph = PH_HUNT;
        end
      end
      PH_CR: begin
        if (b == CR_CH) begin
          hunt_ph = PH_LF;
        end else if (b == HDR_A_CH) begin
          hunt_ph = PH_CR;
        end else begin
          hunt_ph = PH_HUNT;
        end
      end
      default: begin
        if (b == HDR_A_CH) begin
          hunt_ph = PH_CR;
        end
      end
    endcase
    if (ended) begin
      hunt_ph      = PH_HUNT;
      body_pos     = 0;
      res.st       = st;
      res.distance = held_dist;
      res.vel      = held_vel;
      frame_res_q.push_back(res);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // counted bytes are the ones that count toward a chunk's size; line noise is not
  task automatic push_byte(input logic [7:0] b, input bit counted);
    rx_item_t it;
    it.b    = b;
    it.hold = 1'b0;
    rx_q.push_back(it);
    if (counted) begin
      fed_count++;
    end
  endtask

  task automatic push_hold();
    rx_item_t it;
    it.b    = 8'h00;
    it.hold = 1'b1;
    rx_q.push_back(it);
  endtask

  task automatic push_header();
    push_byte(HDR_A_CH, 1'b1);
    push_byte(CR_CH, 1'b1);
    push_byte(LF_CH, 1'b1);
  endtask

  // header, body text, then the cr lf that closes the body
  task automatic push_frame_str(input string s);
    push_header();
    for (int k = 0; k < s.len(); k++) begin
      push_byte(s[k], 1'b1);
    end
    push_byte(CR_CH, 1'b1);
    push_byte(LF_CH, 1'b1);
  endtask

  // mostly digits, now and then any byte except the decimal point
  function automatic logic [7:0] rand_body_byte();
    logic [7:0] b;
    if ($urandom_range(0, 11) == 0) begin
      b = 8'($urandom_range(0, 255));
      if (b == POINT_CH) begin
        b = ZERO_CH;
      end
    end else begin
      b = 8'(ZERO_CH + $urandom_range(0, 9));
    end
    return b;
  endfunction

  // frame with random digits: a good or bad distance and velocity layout
  // picked at random, sometimes a short body, sometimes an overflow
  task automatic gen_frame();
    logic [7:0] fb [RAFP_BODY_DEPTH];
    int         sh;
    int         p;
    int         e;
    for (int k = 0; k < RAFP_BODY_DEPTH; k++) begin
      fb[k] = rand_body_byte();
    end
    // 0: point at 3, 1: point at 4, 2: no point, bad distance
    sh = $urandom_range(0, 2);
    if (sh < 2) begin
      fb[3 + sh] = POINT_CH;
    end
    p = 8 + sh;
    case ($urandom_range(0, 4))
      0: fb[p] = POINT_CH;
      1: fb[p + 2] = POINT_CH;
      2: begin
        fb[p + 1] = POINT_CH;
        fb[p - 1] = MINUS_CH;
      end
      3: fb[p + 1] = POINT_CH;
      default: ;
    endcase
    push_header();
    e = $urandom_range(0, 9);
    if (e == 0) begin
      // no terminator: the last store position overflows
      for (int k = 0; k < RAFP_BODY_DEPTH; k++) begin
        push_byte(fb[k], 1'b1);
      end
    end else begin
      e = (e == 1) ? $urandom_range(0, 13) : $urandom_range(14, RAFP_BODY_DEPTH - 2);
      for (int k = 0; k < e; k++) begin
        push_byte(fb[k], 1'b1);
      end
      push_byte(CR_CH, 1'b1);
      push_byte(LF_CH, 1'b1);
    end
  endtask

  // cut-off headers, or a header with a few body bytes and no terminator,
  // so the next frame's bytes land in that body
  task automatic gen_broken();
    case ($urandom_range(0, 3))
      0: push_byte(HDR_A_CH, 1'b1);
      1: begin
        push_byte(HDR_A_CH, 1'b1);
        push_byte(CR_CH, 1'b1);
      end
      2: begin
        push_byte(HDR_A_CH, 1'b1);
        push_byte(CR_CH, 1'b1);
        push_byte(8'($urandom_range(0, 9)), 1'b1);
      end
      default: begin
        push_header();
        repeat ($urandom_range(1, 5)) push_byte(rand_body_byte(), 1'b1);
      end
    endcase
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_LINES) begin
      $display("%0t ns mismatch: %s", $realtime, what);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: one byte word at a time from rx_q, random idle gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_parser(in_rx_byte);
      end
      // free to present a new word unless the current one is still waiting
      if (!in_valid || in_ready) begin
        if (rx_q.size() != 0 && rx_q[0].hold && frame_res_q.size() == 0) begin
          rx_q.delete(0);
        end
        if (rx_q.size() != 0 && !rx_q[0].hold && $urandom_range(0, 99) >= idle_pct) begin
          nxt = rx_q.pop_front();
          in_valid   <= 1'b1;
          in_rx_byte <= nxt.b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: take result words, compare with the oldest expected one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_res_q.size() == 0) begin
          report_mismatch($sformatf("result word with none expected, status %0d", out_status));
        end else begin
          want = frame_res_q.pop_front();
          if (out_status !== want.st) begin
            report_mismatch($sformatf("status got %0d want %0d", out_status, want.st));
          end
          if (out_distance !== want.distance) begin
            report_mismatch($sformatf("distance got %0d want %0d",
                                      out_distance, want.distance));
          end
          if (out_velocity !== want.vel) begin
            report_mismatch($sformatf("velocity got %0d want %0d",
                                      out_velocity, $signed(want.vel)));
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > WATCHDOG_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: reset, directed frames, then random chunks per idling phase
  // ---------------------------------------------------------------------------
  initial begin
    int idle_tbl [4];
    int stall_tbl [4];
    int chunk_start;
    int pick;
    idle_tbl  = '{0, 64, 0, 14};
    stall_tbl = '{0, 0, 64, 14};

    // directed, no idling; ignored extremes of the byte first
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    // long first body so every position the decoder reads has been written
    push_frame_str("001.23 4.56000");
    // point at 3: velocity with point at 10 (negative), at 9 with and without minus
    push_frame_str("009.99 -99.990");
    push_frame_str("005.00 -1.2300");
    push_frame_str("000.00 12.3400");
    // point at 4: velocity with point at 9, at 11 (negative), at 10 +/- minus
    push_frame_str("0099.99 9.9900");
    push_frame_str("0012.34 -56.78");
    push_frame_str("0001.00 -1.230");
    push_frame_str("0001.00 12.340");
    // bad velocity format keeps velocity but takes the distance
    push_frame_str("007.50 abcdefg");
    // bad distance format keeps both
    push_frame_str("abcdefghijklmn");
    // non-digit bytes wrap: all-ones distance digits, all-zero velocity digits
    push_header();
    for (int k = 0; k < 14; k++) begin
      if (k == 4 || k == 9) begin
        push_byte(POINT_CH, 1'b1);
      end else begin
        push_byte((k < 8) ? 8'hFF : 8'h00, 1'b1);
      end
    end
    push_byte(CR_CH, 1'b1);
    push_byte(LF_CH, 1'b1);
    // lf as first body byte does not end the body
    push_header();
    push_byte(LF_CH, 1'b1);
    push_frame_str("01.23 4.56");
    // cr lf right after the header: short body decodes older bytes
    push_header();
    push_byte(CR_CH, 1'b1);
    push_byte(LF_CH, 1'b1);
    // overflow on the last store position
    push_header();
    repeat (RAFP_BODY_DEPTH) push_byte(8'h39, 1'b1);
    // terminator exactly in the last two positions still ends the frame
    push_header();
    repeat (RAFP_BODY_DEPTH - 2) push_byte(8'h35, 1'b1);
    push_byte(CR_CH, 1'b1);
    push_byte(LF_CH, 1'b1);
    // hunter restarts: repeated header byte, header byte or cr where lf is due
    push_byte(HDR_A_CH, 1'b1);
    push_frame_str("002.50 1.5000");
    push_byte(HDR_A_CH, 1'b1);
    push_byte(CR_CH, 1'b1);
    push_frame_str("0100.00 -7.500");
    push_byte(HDR_A_CH, 1'b1);
    push_byte(CR_CH, 1'b1);
    push_byte(CR_CH, 1'b1);
    push_frame_str("003.33 3.3300");

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (rx_q.size() != 0) @(negedge clk);

    // random part, two rounds through the idling phases
    for (int round = 0; round < 2; round++) begin
      for (int ph = 0; ph < 4; ph++) begin
        idle_pct  = idle_tbl[ph];
        stall_pct = stall_tbl[ph];
        // in the first round, sender waits for all outstanding words before this chunk
        if (round == 0) begin
          push_hold();
        end
        chunk_start = fed_count;
        while (fed_count - chunk_start < CHUNK_BYTES) begin
          pick = $urandom_range(0, 99);
          if (pick < 78) begin
            gen_frame();
          end else if (pick < 90) begin
            gen_broken();
          end else begin
            gen_noise();
          end
        end
        while (rx_q.size() != 0) @(negedge clk);
      end
    end

    // drain: last word out, then a wait for a trailing byte in flight
    while (rx_q.size() != 0 || in_valid) @(negedge clk);
    while (frame_res_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/rafp_pkg.sv
hdl/rafp_decode.sv
hdl/radar_ascii_frame_parser_unit.sv
test/radar_ascii_frame_parser_unit_tb.sv
